FILE: hdl/annexb_nal_splitter_assert.svh
// Assertion macros for the NAL splitter, clocked on aclk, disabled in reset.
`ifndef ANNEXB_NAL_SPLITTER_ASSERT_SVH
`define ANNEXB_NAL_SPLITTER_ASSERT_SVH

// Same-cycle implication.
`define ANB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("annexb_nal_splitter: same-cycle check failed");

// Next-cycle implication.
`define ANB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("annexb_nal_splitter: next-cycle check failed");

`endif

FILE: hdl/anb_pkg.sv
package anb_pkg;

    localparam int MAX_RES = 5;
    localparam int CNT_W   = 3;

    localparam logic [7:0] ZERO_BYTE  = 8'h00;
    localparam logic [7:0] START_BYTE = 8'h01;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] nal_byte;
        logic       nal_first;
        logic       nal_last;
        logic       unit_end;
    } out_beat_t;

    typedef struct packed {
        logic [1:0] zero_run;
        logic       synced;
        logic [7:0] held_byte;
        logic       held_valid;
        logic       next_is_first;
    } state_t;

    typedef struct packed {
        out_beat_t [MAX_RES-1:0] items;
        logic [CNT_W-1:0]        count;
    } step_res_t;

    localparam state_t STATE_RESET = '{
        zero_run:      2'd0,
        synced:        1'b0,
        held_byte:     8'h00,
        held_valid:    1'b0,
        next_is_first: 1'b1
    };

    function automatic out_beat_t mk_beat(logic [7:0] b, logic last, logic ue);
        out_beat_t r;
        r.nal_byte  = b;
        r.nal_first = 1'b0;
        r.nal_last  = last;
        r.unit_end  = last & ue;
        return r;
    endfunction

endpackage

FILE: hdl/anb_step.sv
module anb_step (
    input  anb_pkg::state_t    st,
    input  anb_pkg::in_beat_t  beat,
    output anb_pkg::state_t    st_next,
    output anb_pkg::step_res_t res
);

    always_comb begin
        logic [1:0]               zr;
        logic                     sy;
        logic [7:0]               hb;
        logic                     hv;
        logic                     is_start;
        logic                     eob;
        logic [2:0]               total;
        logic [anb_pkg::CNT_W-1:0] n;
        anb_pkg::out_beat_t [anb_pkg::MAX_RES-1:0] items;

        zr       = st.zero_run;
        sy       = st.synced;
        hb       = st.held_byte;
        hv       = st.held_valid;
        eob      = beat.end_of_buffer;
        n        = '0;
        items    = '0;
        total    = '0;
        is_start = (beat.data_byte == anb_pkg::START_BYTE) && (zr >= 2'd2);

        if (is_start) begin
            if (sy && hv) begin
                items[n] = anb_pkg::mk_beat(hb, 1'b1, eob);
                n = n + 3'd1;
            end
            sy = 1'b1;
            hv = 1'b0;
            zr = 2'd0;
        end else if (beat.data_byte == anb_pkg::ZERO_BYTE) begin
            if (zr != 2'd3) begin
                zr = zr + 2'd1;
            end else if (sy) begin
                if (hv) begin
                    items[n] = anb_pkg::mk_beat(hb, 1'b0, 1'b0);
                    n = n + 3'd1;
                end
                hb = anb_pkg::ZERO_BYTE;
                hv = 1'b1;
            end
        end else begin
            if (sy) begin
                if (hv) begin
                    items[n] = anb_pkg::mk_beat(hb, 1'b0, 1'b0);
                    n = n + 3'd1;
                end
                for (int k = 0; k < 3; k++) begin
                    if (2'(k) < zr) begin
                        items[n] = anb_pkg::mk_beat(anb_pkg::ZERO_BYTE, 1'b0, 1'b0);
                        n = n + 3'd1;
                    end
                end
                hb = beat.data_byte;
                hv = 1'b1;
            end
            zr = 2'd0;
        end

        if (eob && sy) begin
            total = {2'b00, hv} + {1'b0, zr};
            for (int k = 0; k < 4; k++) begin
                if (3'(k) < total) begin
                    items[n] = anb_pkg::mk_beat((k == 0 && hv) ? hb : anb_pkg::ZERO_BYTE,
                                                3'(k + 1) == total, 1'b1);
                    n = n + 3'd1;
                end
            end
        end

        items[0].nal_first = st.next_is_first && (n != '0);

        res.items = items;
        res.count = n;

        if (eob) begin
            st_next = anb_pkg::STATE_RESET;
        end else begin
            st_next.zero_run      = zr;
            st_next.synced        = sy;
            st_next.held_byte     = hb;
            st_next.held_valid    = hv;
            st_next.next_is_first = is_start ? 1'b1 : ((n != '0) ? 1'b0 : st.next_is_first);
        end
    end

endmodule

FILE: hdl/annexb_nal_splitter.sv
// Latency: the first result of a byte is offered on m_ the cycle after the byte's beat.
// Throughput: one byte per cycle while each byte yields at most one result and m_ready
// stays high; a byte that yields several results (up to five) holds off further bytes
// until its results have drained, one buffer entry per accepted m_ beat.
// Reset: aresetn synchronous, active low; clears matcher state and the result count (buffer contents are not reset).
`include "annexb_nal_splitter_assert.svh"

module annexb_nal_splitter (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  anb_pkg::in_beat_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output anb_pkg::out_beat_t  m_data
);

    anb_pkg::state_t    state_reg, state_next, step_state;
    anb_pkg::step_res_t step_res;

    anb_pkg::out_beat_t [anb_pkg::MAX_RES-1:0] buf_reg, buf_next;
    logic [anb_pkg::CNT_W-1:0] cnt_reg, cnt_next;

    logic in_fire;
    logic out_fire;

    anb_step u_step (
        .st      (state_reg),
        .beat    (s_data),
        .st_next (step_state),
        .res     (step_res)
    );

    assign m_valid  = (cnt_reg != '0);
    assign m_data   = buf_reg[0];
    assign out_fire = m_valid && m_ready;
    assign s_ready  = (cnt_reg == '0) || ((cnt_reg == 3'd1) && m_ready);
    assign in_fire  = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        buf_next   = buf_reg;
        cnt_next   = cnt_reg;
        if (in_fire) begin
            state_next = step_state;
            buf_next   = step_res.items;
            cnt_next   = step_res.count;
        end else if (out_fire) begin
            for (int i = 0; i < anb_pkg::MAX_RES - 1; i++) begin
                buf_next[i] = buf_reg[i+1];
            end
            cnt_next = cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= anb_pkg::STATE_RESET;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        buf_reg <= buf_next;
    end

    `ANB_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_reg <= 3'd5)
    `ANB_ASSERT_NOW(a_ready_drained, s_ready, cnt_reg <= 3'd1)
    `ANB_ASSERT_NOW(a_held_needs_sync, state_reg.held_valid, state_reg.synced)
    `ANB_ASSERT_NOW(a_marker_on_last, m_valid && m_data.unit_end, m_data.nal_last)
    `ANB_ASSERT_NEXT(a_eob_resets, in_fire && s_data.end_of_buffer,
                     state_reg == anb_pkg::STATE_RESET)

endmodule

FILE: dv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200_000;

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    anb_pkg::in_beat_t  s_data  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    anb_pkg::out_beat_t m_data;

    anb_pkg::state_t    split_state = anb_pkg::STATE_RESET;
    anb_pkg::out_beat_t nal_expected[$];
    anb_pkg::out_beat_t nal_want;
    int        mismatches  = 0;
    int        beats_sent  = 0;
    int        cycle_count = 0;

    int        burst_left  = 0;
    int        gap_max     = 0;
    int        stall_max   = 0;
    int        stall_left  = 0;
    int        run_left    = 0;

    annexb_nal_splitter i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #2 aclk = ~aclk;

    function automatic void emit_nal_byte(logic [7:0] value, logic last, logic ue);
        anb_pkg::out_beat_t r;
        r.nal_byte  = value;
        r.nal_first = split_state.next_is_first;
        r.nal_last  = last;
        r.unit_end  = last & ue;
        nal_expected.push_back(r);
        split_state.next_is_first = 1'b0;
    endfunction

    function automatic void predict_split(anb_pkg::in_beat_t beat);
        logic [7:0] b;
        logic       eob;
        int         total;
        b   = beat.data_byte;
        eob = beat.end_of_buffer;
        if (b == anb_pkg::START_BYTE && split_state.zero_run >= 2) begin
            if (split_state.synced && split_state.held_valid)
                emit_nal_byte(split_state.held_byte, 1'b1, eob);
            split_state.synced        = 1'b1;
            split_state.held_valid    = 1'b0;
            split_state.zero_run      = 2'd0;
            split_state.next_is_first = 1'b1;
        end else if (b == anb_pkg::ZERO_BYTE) begin
            if (split_state.zero_run < 3) begin
                split_state.zero_run = split_state.zero_run + 2'd1;
            end else if (split_state.synced) begin
                // oldest zero of the run moves into the held slot
                if (split_state.held_valid)
                    emit_nal_byte(split_state.held_byte, 1'b0, 1'b0);
                split_state.held_byte  = anb_pkg::ZERO_BYTE;
                split_state.held_valid = 1'b1;
            end
        end else begin
            if (split_state.synced) begin
                if (split_state.held_valid)
                    emit_nal_byte(split_state.held_byte, 1'b0, 1'b0);
                for (int k = 0; k < split_state.zero_run; k++)
                    emit_nal_byte(anb_pkg::ZERO_BYTE, 1'b0, 1'b0);
                split_state.held_byte  = b;
                split_state.held_valid = 1'b1;
            end
            split_state.zero_run = 2'd0;
        end
        if (eob) begin
            if (split_state.synced) begin
                total = int'(split_state.held_valid) + int'(split_state.zero_run);
                for (int k = 0; k < total; k++)
                    emit_nal_byte((k == 0 && split_state.held_valid) ?
                                  split_state.held_byte : anb_pkg::ZERO_BYTE,
                                  k + 1 == total, 1'b1);
            end
            split_state = anb_pkg::STATE_RESET;
        end
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (nal_expected.size() == 0) begin
                    $error("nal_byte: expected none, got %0h", m_data.nal_byte);
                    mismatches++;
                end else begin
                    nal_want = nal_expected.pop_front();
                    check_field("nal_byte", nal_want.nal_byte, m_data.nal_byte);
                    check_field("nal_first", 8'(nal_want.nal_first), 8'(m_data.nal_first));
                    check_field("nal_last", 8'(nal_want.nal_last), 8'(m_data.nal_last));
                    check_field("unit_end", 8'(nal_want.unit_end), 8'(m_data.unit_end));
                end
            end
            if (s_valid && s_ready)
                predict_split(s_data);
        end
    end

    always @(negedge aclk) begin
        if (stall_max == 0) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (run_left > 0) begin
            run_left--;
            m_ready <= 1'b1;
        end else begin
            run_left   = $urandom_range(0, 20);
            stall_left = $urandom_range(1, stall_max);
        end
    end

    task automatic send_beat(logic [7:0] data, logic eob);
        @(negedge aclk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if (gap_max > 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(negedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= '{data_byte: data, end_of_buffer: eob};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        beats_sent++;
    endtask

    task automatic send_stream(logic [7:0] stream[$]);
        foreach (stream[i])
            send_beat(stream[i], i == stream.size() - 1);
    endtask

    task automatic drain;
        @(negedge aclk);
        s_valid <= 1'b0;
        while (nal_expected.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    function automatic logic [7:0] payload_byte();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 3)
            return anb_pkg::ZERO_BYTE;
        else if (pick == 3)
            return anb_pkg::START_BYTE;
        else if (pick == 4)
            return 8'($urandom_range(2, 3));
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_wellformed(int target);
        logic [7:0] stream[$];
        int         pick;
        int         len;
        while (beats_sent < target) begin
            stream = {};
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 4)) stream.push_back(payload_byte());
            repeat ($urandom_range(1, 4)) begin
                pick = $urandom_range(0, 9);
                repeat (pick < 5 ? 2 : (pick < 9 ? 3 : 4))
                    stream.push_back(anb_pkg::ZERO_BYTE);
                stream.push_back(anb_pkg::START_BYTE);
                len = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 10);
                repeat (len) stream.push_back(payload_byte());
            end
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 3)) stream.push_back(anb_pkg::ZERO_BYTE);
            send_stream(stream);
        end
    endtask

    task automatic test_directed;
        logic [7:0] stream[$];
        gap_max   = 0;
        stall_max = 0;
        // stray 01 before sync, 3- and 4-byte codes, empty NAL, long zero run,
        // inner zeros, trailing zero on the final NAL
        stream = {anb_pkg::START_BYTE, anb_pkg::ZERO_BYTE, anb_pkg::ZERO_BYTE,
                  anb_pkg::START_BYTE, 8'hFF,
                  anb_pkg::ZERO_BYTE, anb_pkg::ZERO_BYTE, anb_pkg::ZERO_BYTE,
                  anb_pkg::START_BYTE,
                  anb_pkg::ZERO_BYTE, anb_pkg::ZERO_BYTE, anb_pkg::START_BYTE, 8'h80,
                  anb_pkg::ZERO_BYTE, anb_pkg::ZERO_BYTE, anb_pkg::ZERO_BYTE,
                  anb_pkg::ZERO_BYTE, anb_pkg::START_BYTE,
                  anb_pkg::ZERO_BYTE, anb_pkg::ZERO_BYTE, 8'h02, anb_pkg::ZERO_BYTE};
        send_stream(stream);
        // payload 01 after a single zero; buffer ends on a start code
        stream = {anb_pkg::ZERO_BYTE, anb_pkg::ZERO_BYTE, anb_pkg::START_BYTE, 8'h11,
                  anb_pkg::ZERO_BYTE, anb_pkg::START_BYTE,
                  anb_pkg::ZERO_BYTE, anb_pkg::ZERO_BYTE, anb_pkg::START_BYTE};
        send_stream(stream);
        // never synced
        stream = {8'h42};
        send_stream(stream);
        drain();
    endtask

    task automatic test_full_rate;
        gap_max   = 0;
        stall_max = 0;
        send_wellformed(beats_sent + 60);
        drain();
    endtask

    task automatic test_bursty_buffers;
        gap_max   = 6;
        stall_max = 5;
        send_wellformed(beats_sent + 320);
        drain();
    endtask

    task automatic test_noise;
        gap_max   = 3;
        stall_max = 10;
        repeat (110) begin
            send_beat(($urandom_range(0, 2) == 0) ? payload_byte() : 8'($urandom_range(0, 255)),
                      $urandom_range(0, 11) == 0);
        end
        send_beat(8'($urandom_range(0, 255)), 1'b1);
        drain();
    endtask

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_full_rate();
        test_bursty_buffers();
        test_noise();
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && nal_expected.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $error("timeout after %0d cycles, %0d beats outstanding", cycle_count,
               nal_expected.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/anb_pkg.sv
hdl/anb_step.sv
hdl/annexb_nal_splitter.sv
dv/tb_top.sv
